FILE: rtl/core/dpod_pkg.sv
// Shared types, constants and calendar tables for the date period overlap core.
package dpod_pkg;

  localparam int unsigned YearW    = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned DateW    = YearW + MonthW + DayW;
  localparam int unsigned NumDates = 4;
  localparam int unsigned DayNumW  = 21;
  localparam int unsigned CountW   = 21;
  localparam int unsigned MonOffW  = 9;

  // Stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = ((NumDates * DateW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((CountW + 7) / 8) * 8;

  // ceil(y/4), ceil(y/100) and ceil(y/400) results for a 12-bit year
  localparam int unsigned C4W   = YearW - 1;
  localparam int unsigned C100W = 6;
  localparam int unsigned C400W = 4;

  // floor(x/100) = (x * 5243) >> 19, exact for x below 43690
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int unsigned RecipShift = 19;

  localparam int unsigned DaysPerYear = 365;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   LeapFebDays = 5'd29;

  // Year sits in the low bits of a packed date
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef logic [DayNumW-1:0] day_num_t;

  // Load enables of the five pipeline registers
  typedef struct packed {
    logic conv;
    logic num;
    logic order;
    logic bound;
    logic out;
  } stage_en_t;

  // Length of a month in a common year; zero for a month code that means nothing
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m
  function automatic logic [MonOffW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [MonOffW-1:0] off;
    unique case (m)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/core/dpod_day_num.sv
// Two-stage date checker and day-number converter for one calendar date.
module dpod_day_num #(
  parameter int MaxYear = 4095
) (
  input  logic                clk_i,
  input  dpod_pkg::stage_en_t en_i,
  input  dpod_pkg::date_t     date_i,
  output dpod_pkg::day_num_t  day_num_o,
  output logic                ok_o
);

  localparam int unsigned YW  = dpod_pkg::YearW;
  localparam int unsigned NW  = dpod_pkg::DayNumW;
  localparam int unsigned P100W = YW + 1 + dpod_pkg::RecipW;
  localparam int unsigned P400W = YW - 1 + dpod_pkg::RecipW;

  // ---- stage 1: year terms and coarse range checks
  logic [YW:0]       y_p3, y_p99, y_p399;
  logic [YW-2:0]     q400_in;
  logic [P100W-1:0]  prod100;
  logic [P400W-1:0]  prod400;
  logic              y_ok, m_ok, feb29;

  logic [YW-1:0]                  y_q;
  dpod_pkg::day_num_t             y365_q;
  logic [dpod_pkg::C4W-1:0]       c4_q;
  logic [dpod_pkg::C100W-1:0]     c100_q;
  logic [dpod_pkg::C400W-1:0]     c400_q;
  logic [dpod_pkg::MonOffW-1:0]   mo_off_q;
  logic                           base_ok_q, feb29_q, late_q;

  assign y_p3    = {1'b0, date_i.year} + (YW+1)'(3);
  assign y_p99   = {1'b0, date_i.year} + (YW+1)'(99);
  assign y_p399  = {1'b0, date_i.year} + (YW+1)'(399);
  assign q400_in = y_p399[YW:2];
  assign prod100 = P100W'(y_p99) * P100W'(dpod_pkg::Recip100);
  assign prod400 = P400W'(q400_in) * P400W'(dpod_pkg::Recip100);

  assign y_ok  = 32'(date_i.year) <= 32'(MaxYear);
  assign m_ok  = (date_i.month >= dpod_pkg::MonthJan) && (date_i.month <= dpod_pkg::MonthDec);
  assign feb29 = (date_i.month == dpod_pkg::MonthFeb) && (date_i.day == dpod_pkg::LeapFebDays);

  always_ff @(posedge clk_i) begin
    if (en_i.conv) begin
      y_q       <= date_i.year;
      y365_q    <= NW'(date_i.year) * NW'(dpod_pkg::DaysPerYear);
      c4_q      <= y_p3[YW:2];
      c100_q    <= prod100[dpod_pkg::RecipShift +: dpod_pkg::C100W];
      c400_q    <= prod400[dpod_pkg::RecipShift +: dpod_pkg::C400W];
      // day 0 wraps here but is flagged invalid anyway
      mo_off_q  <= dpod_pkg::MonOffW'(
                     (dpod_pkg::MonOffW+1)'(dpod_pkg::days_before(date_i.month))
                   + (dpod_pkg::MonOffW+1)'(date_i.day) - (dpod_pkg::MonOffW+1)'(1));
      base_ok_q <= y_ok && m_ok && (date_i.day != '0)
                   && ((date_i.day <= dpod_pkg::month_days(date_i.month)) || feb29);
      feb29_q   <= feb29;
      late_q    <= date_i.month > dpod_pkg::MonthFeb;
    end
  end

  // ---- stage 2: leap decision and day-number sum
  logic is_c100, is_c400, leap;

  // ceil(y/N)*N == y means N divides y
  assign is_c100 = ((YW+1)'(c100_q) * (YW+1)'(100)) == {1'b0, y_q};
  assign is_c400 = ((YW+1)'(c400_q) * (YW+1)'(400)) == {1'b0, y_q};
  assign leap    = is_c400 || ((y_q[1:0] == 2'b00) && !is_c100);

  always_ff @(posedge clk_i) begin
    if (en_i.num) begin
      day_num_o <= y365_q + NW'(c4_q) - NW'(c100_q) + NW'(c400_q)
                 + NW'(mo_off_q) + NW'(late_q && leap);
      ok_o      <= base_ok_q && (!feb29_q || leap);
    end
  end

endmodule

FILE: rtl/core/dpod_overlap.sv
// Three-stage period ordering, overlap bounds and inclusive day count.
module dpod_overlap (
  input  logic                                     clk_i,
  input  dpod_pkg::stage_en_t                      en_i,
  input  dpod_pkg::day_num_t [dpod_pkg::NumDates-1:0] day_num_i,
  input  logic [dpod_pkg::NumDates-1:0]            ok_i,
  output logic [dpod_pkg::CountW-1:0]              count_o,
  output logic                                     err_o
);

  dpod_pkg::day_num_t s1_q, e1_q, s2_q, e2_q, s_q, e_q;
  logic               bad3_q, bad4_q;

  // ---- stage 3: put each period in order
  always_ff @(posedge clk_i) begin
    if (en_i.order) begin
      s1_q   <= (day_num_i[0] > day_num_i[1]) ? day_num_i[1] : day_num_i[0];
      e1_q   <= (day_num_i[0] > day_num_i[1]) ? day_num_i[0] : day_num_i[1];
      s2_q   <= (day_num_i[2] > day_num_i[3]) ? day_num_i[3] : day_num_i[2];
      e2_q   <= (day_num_i[2] > day_num_i[3]) ? day_num_i[2] : day_num_i[3];
      bad3_q <= ~&ok_i;
    end
  end

  // ---- stage 4: later start, earlier end
  always_ff @(posedge clk_i) begin
    if (en_i.bound) begin
      s_q    <= (s1_q > s2_q) ? s1_q : s2_q;
      e_q    <= (e1_q < e2_q) ? e1_q : e2_q;
      bad4_q <= bad3_q;
    end
  end

  // ---- stage 5: count, zero when disjoint or invalid
  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      count_o <= (bad4_q || (s_q > e_q)) ? '0
               : dpod_pkg::CountW'(e_q - s_q) + dpod_pkg::CountW'(1);
      err_o   <= bad4_q;
    end
  end

endmodule

FILE: rtl/core/date_period_overlap_days_core.sv
// Top level: overlap day count of two Gregorian date periods, five-stage pipeline.
// Throughput: one item per cycle while the output is not held; each stage register loads whenever it is empty
// or its successor moves, so bubbles are squeezed out under output back-pressure.
// Reset: rst_ni (async, active low) clears all stage valid bits; no clearing pass.
module date_period_overlap_days_core #(
  parameter int MAX_YEAR = 4095   // years above this are flagged invalid
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata, from bit 0 up, 21 bits per date: year(12) month(4) day(5) for
  // first_start, first_end, second_start, second_end; bits 87:84 zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dpod_pkg::InDataW-1:0]  s_axis_tdata,
  // tdata: overlap_days(21), bits 23:21 zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dpod_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: date_error(1)
  output logic [0:0]                    m_axis_tuser
);

  localparam int unsigned NumStages = 5;

  dpod_pkg::stage_en_t                          en;
  logic [NumStages-1:0]                         vld_q, vld_d;
  dpod_pkg::day_num_t [dpod_pkg::NumDates-1:0] day_num;
  logic [dpod_pkg::NumDates-1:0]                date_ok;
  logic [dpod_pkg::CountW-1:0]                  count;
  logic                                         err;

  // A stage loads when it holds nothing or its content moves on this edge.
  assign en.out   = !vld_q[4] || m_axis_tready;
  assign en.bound = !vld_q[3] || en.out;
  assign en.order = !vld_q[2] || en.bound;
  assign en.num   = !vld_q[1] || en.order;
  assign en.conv  = !vld_q[0] || en.num;

  assign s_axis_tready = en.conv;

  always_comb begin
    vld_d[0] = en.conv  ? s_axis_tvalid : vld_q[0];
    vld_d[1] = en.num   ? vld_q[0]      : vld_q[1];
    vld_d[2] = en.order ? vld_q[1]      : vld_q[2];
    vld_d[3] = en.bound ? vld_q[2]      : vld_q[3];
    vld_d[4] = en.out   ? vld_q[3]      : vld_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stages 1-2: one converter per date; all four run in lockstep.
  for (genvar i = 0; i < dpod_pkg::NumDates; i++) begin : g_date
    dpod_day_num #(
      .MaxYear (MAX_YEAR)
    ) u_day_num (
      .clk_i     (clk_i),
      .en_i      (en),
      .date_i    (dpod_pkg::date_t'(s_axis_tdata[i*dpod_pkg::DateW +: dpod_pkg::DateW])),
      .day_num_o (day_num[i]),
      .ok_o      (date_ok[i])
    );
  end

  // Stages 3-5: order each period, intersect, count.
  dpod_overlap u_overlap (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_num_i (day_num),
    .ok_i      (date_ok),
    .count_o   (count),
    .err_o     (err)
  );

  assign m_axis_tvalid = vld_q[4];
  assign m_axis_tdata  = {{(dpod_pkg::OutDataW - dpod_pkg::CountW){1'b0}}, count};
  assign m_axis_tuser  = err;

endmodule

FILE: rtl/core/dpod_checker.sv
// Port-level checker for the overlap core, bound to the top level.
module dpod_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [dpod_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dpod_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [0:0]                    m_axis_tuser
);

  // Held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held output changed");

  // An invalid date always yields a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[dpod_pkg::CountW-1:0] == '0)
    else $error("error result with nonzero count");

  // Byte padding above the count stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[dpod_pkg::OutDataW-1:dpod_pkg::CountW] == '0)
    else $error("output padding not zero");

  // Month 0 in the first date comes out flagged when m_axis_tready holds while it moves through the pipeline
  a_bad_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready
       && s_axis_tdata[dpod_pkg::YearW +: dpod_pkg::MonthW] == '0)
    ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid && m_axis_tuser[0])
    else $error("invalid month not reported");

endmodule

bind date_period_overlap_days_core dpod_checker u_dpod_checker (.*);
